### design/quic_frame_parser_unit_defines.svh
// Assertion macros for the QUIC frame parser top level
`ifndef QUIC_FRAME_PARSER_UNIT_DEFINES_SVH
`define QUIC_FRAME_PARSER_UNIT_DEFINES_SVH
// same-cycle implication, disabled during reset
`define QFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked during reset too
`define QFP_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

### design/qfp_pkg.sv
// Types and constants of the QUIC frame parser
`timescale 1ns / 1ps
package qfp_pkg;
   localparam int PADDING_COUNT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int VAL_W = 62;
   localparam logic [7:0] RESET_TOKEN_BYTES = 8'(128 / 8);
   localparam logic [7:0] FT_PING = 8'h01;
   localparam logic [7:0] FT_ACK = 8'h02;
   localparam logic [7:0] FT_ACK_ECN = 8'h03;
   localparam logic [7:0] FT_STOP_SENDING = 8'h05;
   localparam logic [7:0] FT_CRYPTO = 8'h06;
   localparam logic [7:0] FT_NEW_CID = 8'h18;
   localparam logic [7:0] FT_HS_DONE = 8'h1E;
   localparam logic [7:0] VARINT_MASK = 8'b0011_1111;
   localparam int ST_OFF_BIT = 2;
   localparam int ST_LEN_BIT = 1;

   typedef enum logic [2:0] {
      RK_FRAME = 3'd0, RK_DATA = 3'd1, RK_ACK_PAIR = 3'd2, RK_PADDING = 3'd3,
      RK_STOPPED = 3'd4, RK_TRUNCATED = 3'd5, RK_ECN = 3'd6
   } kind_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [2:0]       report_kind;
      logic [7:0]       type_code;
      logic [VAL_W-1:0] value_a;
      logic [VAL_W-1:0] value_b;
      logic [VAL_W-1:0] value_c;
      logic [VAL_W-1:0] value_d;
      logic [7:0]       data_value;
      logic [VAL_W-1:0] data_offset;
      logic             last_of_payload;
   } rsp_type;

   // reports caused by one payload byte
   typedef struct packed {
      logic [1:0] count;
      rsp_type    rep0;
      rsp_type    rep1;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef enum logic [22:0] {
      PH_TYPE        = 23'd1 << 0,
      PH_ACK_LARGEST = 23'd1 << 1,
      PH_ACK_DELAY   = 23'd1 << 2,
      PH_ACK_COUNT   = 23'd1 << 3,
      PH_ACK_FIRST   = 23'd1 << 4,
      PH_ACK_GAP     = 23'd1 << 5,
      PH_ACK_RANGE   = 23'd1 << 6,
      PH_ECN0        = 23'd1 << 7,
      PH_ECN1        = 23'd1 << 8,
      PH_ECNCE       = 23'd1 << 9,
      PH_SS_ID       = 23'd1 << 10,
      PH_SS_ERR      = 23'd1 << 11,
      PH_CR_OFF      = 23'd1 << 12,
      PH_CR_LEN      = 23'd1 << 13,
      PH_ST_ID       = 23'd1 << 14,
      PH_ST_OFF      = 23'd1 << 15,
      PH_ST_LEN      = 23'd1 << 16,
      PH_NC_SEQ      = 23'd1 << 17,
      PH_NC_RETIRE   = 23'd1 << 18,
      PH_NC_LEN      = 23'd1 << 19,
      PH_DATA        = 23'd1 << 20,
      PH_DATA_TO_END = 23'd1 << 21,
      PH_STOPPED     = 23'd1 << 22
   } phase_type;
endpackage

### design/qfp_parser.sv
// Front end: decodes one payload byte a cycle when in_valid, into up to two reports
`timescale 1ns / 1ps
module qfp_parser #(
   parameter int PADDING_COUNT_BITS = qfp_pkg::PADDING_COUNT_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qfp_pkg::req_type   in_word,
   output logic               push,
   output qfp_pkg::entry_type push_entry
);
   import qfp_pkg::*;

   localparam logic [PADDING_COUNT_BITS-1:0] PAD_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [7:0]             ctype_ff, ctype_in;
   logic [VAL_W-1:0]       vacc_ff, vacc_in;
   logic [2:0]             vleft_ff, vleft_in;
   logic [VAL_W-1:0]       cap0_ff, cap0_in, cap1_ff, cap1_in, cap2_ff, cap2_in;
   logic [VAL_W-1:0]       dleft_ff, dleft_in, dpos_ff, dpos_in, aleft_ff, aleft_in;
   logic [PADDING_COUNT_BITS-1:0] pad_ff, pad_in;

   rsp_type    pad_rep, main_rep, tail_rep;
   logic       pad_v, main_v, tail_v, st_done, done, is_varint;
   logic [7:0] b;
   logic [VAL_W-1:0] v;

   function automatic rsp_type mk(input logic [2:0] k, input logic [7:0] t,
                                  input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] bb,
                                  input logic [VAL_W-1:0] c, input logic [VAL_W-1:0] d,
                                  input logic [7:0] dv, input logic [VAL_W-1:0] doff);
      rsp_type r;
      r.report_kind = k; r.type_code = t; r.value_a = a; r.value_b = bb;
      r.value_c = c; r.value_d = d; r.data_value = dv; r.data_offset = doff;
      r.last_of_payload = 1'b0;
      return r;
   endfunction

   // next-state and report generation
   always_comb begin
      b = in_word.payload_byte;
      phase_in = phase_ff; ctype_in = ctype_ff; vacc_in = vacc_ff; vleft_in = vleft_ff;
      cap0_in = cap0_ff; cap1_in = cap1_ff; cap2_in = cap2_ff;
      dleft_in = dleft_ff; dpos_in = dpos_ff; aleft_in = aleft_ff; pad_in = pad_ff;
      pad_v = 1'b0; main_v = 1'b0; tail_v = 1'b0; st_done = 1'b0; done = 1'b0;
      pad_rep = mk(RK_PADDING, 8'h00, VAL_W'(pad_ff), '0, '0, '0, 8'h00, '0);
      main_rep = '0; tail_rep = '0;
      is_varint = phase_ff[1] | phase_ff[2] | phase_ff[3] | phase_ff[4] | phase_ff[5]
                | phase_ff[6] | phase_ff[7] | phase_ff[8] | phase_ff[9] | phase_ff[10]
                | phase_ff[11] | phase_ff[12] | phase_ff[13] | phase_ff[14]
                | phase_ff[15] | phase_ff[16] | phase_ff[17] | phase_ff[18];
      // varint byte
      if (vleft_ff == 3'd0) begin
         vacc_in = VAL_W'(b & VARINT_MASK);
         vleft_in = 3'((4'd1 << b[7:6]) - 4'd1);
      end else begin
         vacc_in = {vacc_ff[VAL_W-9:0], b};
         vleft_in = vleft_ff - 3'd1;
      end
      done = (vleft_in == 3'd0);
      v = vacc_in;
      if (!is_varint) begin
         vacc_in = vacc_ff; vleft_in = vleft_ff;
      end
      unique case (phase_ff)
         PH_STOPPED: ;
         PH_TYPE: begin
            if (b == 8'h00) begin
               if (pad_ff < PAD_MAX) pad_in = pad_ff + 1'b1;
            end else begin
               pad_v = (pad_ff != '0);
               pad_in = '0;
               ctype_in = b;
               vleft_in = 3'd0;
               if (b == FT_PING || b == FT_HS_DONE) begin
                  main_v = 1'b1;
                  main_rep = mk(RK_FRAME, b, '0, '0, '0, '0, 8'h00, '0);
               end else if (b == FT_ACK || b == FT_ACK_ECN) phase_in = PH_ACK_LARGEST;
               else if (b == FT_STOP_SENDING) phase_in = PH_SS_ID;
               else if (b == FT_CRYPTO) phase_in = PH_CR_OFF;
               else if (b[7:3] == 5'b00001) phase_in = PH_ST_ID;
               else if (b == FT_NEW_CID) phase_in = PH_NC_SEQ;
               else begin
                  main_v = 1'b1;
                  main_rep = mk(RK_STOPPED, b, '0, '0, '0, '0, 8'h00, '0);
                  phase_in = PH_STOPPED;
               end
            end
         end
         PH_NC_LEN: begin
            cap2_in = VAL_W'(b);
            main_v = 1'b1;
            main_rep = mk(RK_FRAME, ctype_ff, cap0_ff, cap1_ff, VAL_W'(b), '0, 8'h00, '0);
            dpos_in = '0;
            dleft_in = VAL_W'(b) + VAL_W'(RESET_TOKEN_BYTES);
            phase_in = PH_DATA;
         end
         PH_DATA, PH_DATA_TO_END: begin
            main_v = 1'b1;
            main_rep = mk(RK_DATA, ctype_ff, '0, '0, '0, '0, b, dpos_ff);
            dpos_in = dpos_ff + 1'b1;
            if (phase_ff == PH_DATA) begin
               if (dleft_ff != '0) dleft_in = dleft_ff - 1'b1;
               if (dleft_in == '0) phase_in = PH_TYPE;
            end
         end
         default: begin
            // varint field phases
            if (done) begin
               unique case (phase_ff)
                  PH_ACK_LARGEST: begin cap0_in = v; phase_in = PH_ACK_DELAY; end
                  PH_ACK_DELAY: begin cap1_in = v; phase_in = PH_ACK_COUNT; end
                  PH_ACK_COUNT: begin
                     cap2_in = v; aleft_in = v; phase_in = PH_ACK_FIRST;
                  end
                  PH_ACK_FIRST, PH_ACK_RANGE: begin
                     main_v = 1'b1;
                     if (phase_ff == PH_ACK_FIRST)
                        main_rep = mk(RK_FRAME, ctype_ff, cap0_ff, cap1_ff, cap2_ff, v,
                                      8'h00, '0);
                     else begin
                        main_rep = mk(RK_ACK_PAIR, ctype_ff, cap0_ff, v, '0, '0, 8'h00, '0);
                        aleft_in = aleft_ff - 1'b1;
                     end
                     if (aleft_in != '0) phase_in = PH_ACK_GAP;
                     else if (ctype_ff == FT_ACK_ECN) phase_in = PH_ECN0;
                     else phase_in = PH_TYPE;
                  end
                  PH_ACK_GAP: begin cap0_in = v; phase_in = PH_ACK_RANGE; end
                  PH_ECN0: begin cap0_in = v; phase_in = PH_ECN1; end
                  PH_ECN1: begin cap1_in = v; phase_in = PH_ECNCE; end
                  PH_ECNCE: begin
                     main_v = 1'b1;
                     main_rep = mk(RK_ECN, ctype_ff, cap0_ff, cap1_ff, v, '0, 8'h00, '0);
                     phase_in = PH_TYPE;
                  end
                  PH_SS_ID: begin cap0_in = v; phase_in = PH_SS_ERR; end
                  PH_SS_ERR: begin
                     main_v = 1'b1;
                     main_rep = mk(RK_FRAME, ctype_ff, cap0_ff, v, '0, '0, 8'h00, '0);
                     phase_in = PH_TYPE;
                  end
                  PH_CR_OFF: begin cap0_in = v; phase_in = PH_CR_LEN; end
                  PH_CR_LEN: begin
                     main_v = 1'b1;
                     main_rep = mk(RK_FRAME, ctype_ff, cap0_ff, v, '0, '0, 8'h00, '0);
                     dpos_in = cap0_ff; dleft_in = v;
                     phase_in = (v != '0) ? PH_DATA : PH_TYPE;
                  end
                  PH_ST_ID: begin
                     cap0_in = v; cap1_in = '0; cap2_in = '0;
                     if (ctype_ff[ST_OFF_BIT]) phase_in = PH_ST_OFF;
                     else if (ctype_ff[ST_LEN_BIT]) phase_in = PH_ST_LEN;
                     else st_done = 1'b1;
                  end
                  PH_ST_OFF: begin
                     cap1_in = v;
                     if (ctype_ff[ST_LEN_BIT]) phase_in = PH_ST_LEN;
                     else st_done = 1'b1;
                  end
                  PH_ST_LEN: begin cap2_in = v; st_done = 1'b1; end
                  PH_NC_SEQ: begin cap0_in = v; phase_in = PH_NC_RETIRE; end
                  PH_NC_RETIRE: begin cap1_in = v; phase_in = PH_NC_LEN; end
                  default: phase_in = PH_TYPE;
               endcase
            end
         end
      endcase
      // stream header complete
      if (st_done) begin
         main_v = 1'b1;
         main_rep = mk(RK_FRAME, ctype_ff, cap0_in, cap1_in, cap2_in, '0, 8'h00, '0);
         dpos_in = cap1_in;
         if (ctype_ff[ST_LEN_BIT]) begin
            dleft_in = cap2_in;
            phase_in = (cap2_in != '0) ? PH_DATA : PH_TYPE;
         end else phase_in = PH_DATA_TO_END;
      end
      // end of payload: closing report and return to reset state
      if (in_word.end_of_payload) begin
         if (phase_in == PH_TYPE) begin
            tail_v = (pad_in != '0);
            tail_rep = mk(RK_PADDING, 8'h00, VAL_W'(pad_in), '0, '0, '0, 8'h00, '0);
         end else if (phase_in != PH_DATA_TO_END && phase_in != PH_STOPPED) begin
            tail_v = 1'b1;
            tail_rep = mk(RK_TRUNCATED, ctype_in, '0, '0, '0, '0, 8'h00, '0);
         end
         phase_in = PH_TYPE; ctype_in = '0; vacc_in = '0; vleft_in = '0;
         cap0_in = '0; cap1_in = '0; cap2_in = '0;
         dleft_in = '0; dpos_in = '0; aleft_in = '0; pad_in = '0;
      end
   end

   // pack reports in order: padding, frame, closing
   always_comb begin
      push_entry.count = 2'(pad_v) + 2'(main_v) + 2'(tail_v);
      push_entry.rep0 = pad_v ? pad_rep : (main_v ? main_rep : tail_rep);
      push_entry.rep1 = pad_v ? (main_v ? main_rep : tail_rep) : tail_rep;
      if (in_word.end_of_payload) begin
         if (push_entry.count == 2'd2) push_entry.rep1.last_of_payload = 1'b1;
         else push_entry.rep0.last_of_payload = 1'b1;
      end
      push = in_valid && (push_entry.count != 2'd0);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE; ctype_ff <= '0; vacc_ff <= '0; vleft_ff <= '0;
         cap0_ff <= '0; cap1_ff <= '0; cap2_ff <= '0;
         dleft_ff <= '0; dpos_ff <= '0; aleft_ff <= '0; pad_ff <= '0;
      end else if (in_valid) begin
         phase_ff <= phase_in; ctype_ff <= ctype_in; vacc_ff <= vacc_in;
         vleft_ff <= vleft_in; cap0_ff <= cap0_in; cap1_ff <= cap1_in;
         cap2_ff <= cap2_in; dleft_ff <= dleft_in; dpos_ff <= dpos_in;
         aleft_ff <= aleft_in; pad_ff <= pad_in;
      end
   end
endmodule

### design/qfp_queue.sv
// Short word queue between parser and emitter
`timescale 1ns / 1ps
module qfp_queue #(
   parameter int DEPTH = qfp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qfp_pkg::entry_type push_entry,
   input  logic               pop,
   output qfp_pkg::entry_type head,
   output qfp_pkg::qstat_type status
);
   import qfp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   // pointer arithmetic with wrap
   always_comb begin
      wr_in = wr_ff; rd_in = rd_ff; cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
      status.empty = (cnt_ff == '0);
      status.full = (cnt_ff == CW'(DEPTH));
      head = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end
endmodule

### design/qfp_emitter.sv
// Back end: hands out the reports of each queued word one at a time
`timescale 1ns / 1ps
module qfp_emitter (
   input  logic               clock,
   input  logic               reset,
   input  qfp_pkg::entry_type head,
   input  qfp_pkg::qstat_type status,
   output logic               q_pop,
   input  logic               out_pop,
   output logic               out_empty,
   output qfp_pkg::rsp_type   out_word
);
   import qfp_pkg::*;

   entry_type slot_ff, slot_in;
   logic      valid_ff, valid_in, idx_ff, idx_in, drain;

   // slot refill when empty or when its last report is taken
   always_comb begin
      slot_in = slot_ff; valid_in = valid_ff; idx_in = idx_ff;
      drain = !valid_ff || (out_pop && (idx_ff || slot_ff.count != 2'd2));
      q_pop = drain && !status.empty;
      if (valid_ff && out_pop && !idx_ff && slot_ff.count == 2'd2) idx_in = 1'b1;
      else if (drain) begin
         valid_in = !status.empty;
         slot_in = head;
         idx_in = 1'b0;
      end
      out_empty = !valid_ff;
      out_word = idx_ff ? slot_ff.rep1 : slot_ff.rep0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; idx_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end
endmodule

### design/quic_frame_parser_unit.sv
// QUIC frame parser: reports are held in the word queue, then the emitter slot.
// Throughput one byte a cycle while the queue is not full; a byte giving two
// reports goes out one at a time, absorbed by the queue (QUEUE_DEPTH words).
// Synchronous active-high reset empties the queue and returns the parser
// to frame-type phase with all counters cleared; no clearing pass.
`timescale 1ns / 1ps
`include "quic_frame_parser_unit_defines.svh"
module quic_frame_parser_unit #(
   parameter int PADDING_COUNT_BITS = qfp_pkg::PADDING_COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = qfp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  qfp_pkg::req_type req_word,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output qfp_pkg::rsp_type rsp_word
);
   import qfp_pkg::*;

   entry_type push_entry, head;
   qstat_type status;
   logic      accept, push, q_pop;

   assign req_full = status.full;
   assign accept = req_push && !status.full;

   qfp_parser #(.PADDING_COUNT_BITS(PADDING_COUNT_BITS)) u_parser (
      .clock, .reset, .in_valid(accept), .in_word(req_word),
      .push, .push_entry);

   qfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .push, .push_entry, .pop(q_pop), .head, .status);

   qfp_emitter u_emitter (
      .clock, .reset, .head, .status, .q_pop, .out_pop(rsp_pop),
      .out_empty(rsp_empty), .out_word(rsp_word));

   `QFP_ASSERT_NOW(a_push_has_reports, clock, reset, push, push_entry.count != 2'd0, "empty word pushed")
   `QFP_ASSERT_NOW(a_last_on_end, clock, reset, push && !req_word.end_of_payload, !push_entry.rep0.last_of_payload && !push_entry.rep1.last_of_payload, "last flag without end")
   `QFP_ASSERT_NEXT(a_reset_clears, clock, reset, rsp_empty && !req_full, "reset left state")
endmodule
